/* sv/ptbl_pkg.sv */
// shared types and constants of the per-client token bucket limiter
// used by ptbl_ctrl, ptbl_dp and the top level; depends on nothing else
package ptbl_pkg;

  localparam int TIME_BITS = 48;
  localparam int SLOT_BITS = 8;
  localparam int LEVEL_BITS = 32;
  localparam int COUNT_BITS = 20;
  localparam int CFG_BITS = 20;

  // fixed point: one token is 60000 units
  localparam logic [LEVEL_BITS-1:0] UNITS_PER_TOKEN = 32'd60000;
  localparam logic [LEVEL_BITS-1:0] FRESH_UNITS = 32'd600000;
  localparam logic [TIME_BITS-1:0] HOUR_MS = 48'd3600000;
  localparam logic [TIME_BITS-1:0] DAY_MS = 48'd86400000;

  // register indexes
  localparam logic [1:0] REG_TOKENS_PER_MINUTE = 2'd0;
  localparam logic [1:0] REG_HOURLY_LIMIT = 2'd1;
  localparam logic [1:0] REG_BURST_CAP = 2'd2;

  localparam logic [15:0] TPM_RESET = 16'd100;
  localparam logic [COUNT_BITS-1:0] HLIM_RESET = 20'd1000;
  localparam logic [LEVEL_BITS-1:0] CAP_RESET = 32'd1200000;

  // verdict codes
  localparam logic [1:0] VERDICT_GRANT = 2'd0;
  localparam logic [1:0] VERDICT_HOURLY = 2'd1;
  localparam logic [1:0] VERDICT_TOKENS = 2'd2;

  typedef struct packed {
    logic [SLOT_BITS-1:0] client_slot;
    logic [TIME_BITS-1:0] now_ms;
  } ptbl_in_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] verdict;
  } ptbl_out_t;

  typedef struct packed {
    logic                  valid;
    logic [LEVEL_BITS-1:0] level;
    logic [TIME_BITS-1:0]  last_ms;
    logic [TIME_BITS-1:0]  wstart_ms;
    logic [COUNT_BITS-1:0] count;
  } ptbl_entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic mul;
    logic commit;
  } ptbl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ptbl_sts_t;

endpackage

/* sv/ptbl_ctrl.sv */
// sequencer of the token bucket limiter: clearing pass, accept, evaluate, multiply, decide
// depends on ptbl_pkg
module ptbl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ptbl_pkg::ptbl_sts_t sts,
  output ptbl_pkg::ptbl_cmd_t cmd
);
  import ptbl_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_MUL    = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* sv/ptbl_dp.sv */
// datapath of the token bucket limiter: config registers, slot table, refill and decision
// depends on ptbl_pkg; driven by ptbl_ctrl
module ptbl_dp #(
  parameter int CLIENT_SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptbl_pkg::ptbl_cmd_t             cmd,
  output ptbl_pkg::ptbl_sts_t             sts,
  input  ptbl_pkg::ptbl_in_t              in_data,
  output ptbl_pkg::ptbl_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [ptbl_pkg::CFG_BITS-1:0]   cfg_data
);
  import ptbl_pkg::*;

  localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

  // config
  logic [15:0]           tpm;
  logic [COUNT_BITS-1:0] hlim;
  logic [LEVEL_BITS-1:0] cap_units;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpm <= TPM_RESET;
      hlim <= HLIM_RESET;
      cap_units <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOKENS_PER_MINUTE: tpm <= cfg_data[15:0];
        REG_HOURLY_LIMIT:      hlim <= cfg_data;
        REG_BURST_CAP:         cap_units <= LEVEL_BITS'(cfg_data[15:0]) * UNITS_PER_TOKEN;
        default: ;
      endcase
    end
  end

  // slot index modulo the table depth
  logic [SLOT_BITS-1:0] slot_rem;
  logic [SLOT_W-1:0]    slot_idx;

  always_comb begin
    slot_rem = in_data.client_slot;
    for (int k = SLOT_BITS - 1; k >= 0; k--) begin
      if (32'(slot_rem) >= (CLIENT_SLOTS << k))
        slot_rem = slot_rem - SLOT_BITS'(CLIENT_SLOTS << k);
    end
    slot_idx = SLOT_W'(slot_rem);
  end

  // clearing pass address
  logic [SLOT_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + 1'b1;
  end

  assign sts.clear_last = (32'(clr_addr) == CLIENT_SLOTS - 1);

  // item registers
  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_BITS-1:0] now_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_q <= slot_idx;
      now_q <= in_data.now_ms;
    end
  end

  // slot table
  ptbl_entry_t mem [CLIENT_SLOTS];
  ptbl_entry_t rd_q;
  ptbl_entry_t wr_entry;
  logic        mem_we;
  logic [SLOT_W-1:0] mem_wa;

  always_ff @(posedge clk) begin
    if (cmd.load) rd_q <= mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= wr_entry;
  end

  // evaluate: open a new or idle slot, elapsed time
  logic [TIME_BITS-1:0]  since_refill;
  logic                  fresh;
  logic [LEVEL_BITS-1:0] lvl0_q;
  logic [TIME_BITS-1:0]  ws0_q;
  logic [COUNT_BITS-1:0] cnt0_q;
  logic [TIME_BITS-1:0]  elapsed_q;

  assign since_refill = now_q - rd_q.last_ms;
  assign fresh = !rd_q.valid || (since_refill > DAY_MS);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      lvl0_q <= fresh ? FRESH_UNITS : rd_q.level;
      ws0_q <= fresh ? now_q : rd_q.wstart_ms;
      cnt0_q <= fresh ? '0 : rd_q.count;
      elapsed_q <= fresh ? '0 : since_refill;
    end
  end

  // multiply: refill units and window expiry
  logic [63:0] prod_q;
  logic        wexp_q;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= {16'b0, elapsed_q} * {48'b0, tpm};
      wexp_q <= (now_q - ws0_q) > HOUR_MS;
    end
  end

  // decide
  logic [LEVEL_BITS:0]   lvl_sum;
  logic [LEVEL_BITS-1:0] lvl_ref;
  logic [LEVEL_BITS-1:0] lvl_fin;
  logic [COUNT_BITS-1:0] cnt_ref;
  logic [COUNT_BITS-1:0] cnt_fin;
  logic [TIME_BITS-1:0]  ws_fin;
  ptbl_out_t             res;

  always_comb begin
    lvl_sum = {1'b0, lvl0_q} + {1'b0, prod_q[LEVEL_BITS-1:0]};
    if (prod_q[63:LEVEL_BITS] != '0 || lvl_sum > {1'b0, cap_units}) lvl_ref = cap_units;
    else lvl_ref = lvl_sum[LEVEL_BITS-1:0];
    cnt_ref = wexp_q ? '0 : cnt0_q;
    ws_fin = wexp_q ? now_q : ws0_q;
    lvl_fin = lvl_ref;
    cnt_fin = cnt_ref;
    res.granted = 1'b0;
    priority if (cnt_ref >= hlim) begin
      res.verdict = VERDICT_HOURLY;
    end else if (lvl_ref < UNITS_PER_TOKEN) begin
      res.verdict = VERDICT_TOKENS;
    end else begin
      res.verdict = VERDICT_GRANT;
      res.granted = 1'b1;
      lvl_fin = lvl_ref - UNITS_PER_TOKEN;
      cnt_fin = cnt_ref + 1'b1;
    end
  end

  always_comb begin
    mem_we = cmd.clear | cmd.commit;
    if (cmd.clear) begin
      mem_wa = clr_addr;
      wr_entry = '0;
    end else begin
      mem_wa = slot_q;
      wr_entry.valid = 1'b1;
      wr_entry.level = lvl_fin;
      wr_entry.last_ms = now_q;
      wr_entry.wstart_ms = ws_fin;
      wr_entry.count = cnt_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data <= res;
  end

endmodule

/* sv/per_client_token_bucket_limiter_unit.sv */
// top level of the per-client token bucket limiter
// instantiates ptbl_ctrl and ptbl_dp; types and constants from ptbl_pkg
//
// Each request beat names a client slot and the current time in ms and gets
// exactly one result beat: granted, or denied with verdict 1 (hourly limit
// reached) or 2 (less than one whole token left). Every slot keeps a token
// bucket in units of 1/60000 token, refilled by elapsed ms times
// tokens_per_minute and capped at burst_cap tokens, plus a count of grants in
// its hourly window. A slot never used, or idle for more than 24 hours, starts
// over with 10 tokens. A new request is accepted only after the previous one
// has run through its steps (accept with table read, slot evaluation, refill
// multiply, decision with write back), set by the read-modify-write of one
// table entry; its result beat is registered when the decision step commits.
// A result beat still waiting at the output holds the next request in its
// decision step, and the request channel stays not ready until the result
// register frees up. After reset the table is cleared one entry a cycle, and
// no request is accepted until every entry is cleared; register writes are
// taken at any time but should be made while the block is idle.
// client_slot values at or above CLIENT_SLOTS wrap modulo CLIENT_SLOTS.
module per_client_token_bucket_limiter_unit #(
  parameter int CLIENT_SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ptbl_pkg::ptbl_in_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output ptbl_pkg::ptbl_out_t           out_data,
  // register writes: 0 tokens_per_minute, 1 hourly_limit, 2 burst_cap
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ptbl_pkg::CFG_BITS-1:0] cfg_data
);
  import ptbl_pkg::*;

  ptbl_cmd_t cmd;
  ptbl_sts_t sts;

  // sequencer: owns the handshakes and the step order
  ptbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: slot table, bucket arithmetic, result register
  ptbl_dp #(
    .CLIENT_SLOTS (CLIENT_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
